// ===== design/mvpm_pkg.sv =====
// Shared types, constants and codes of the multi-voice PCM sample mixer.
package mvpm_pkg;

   localparam int VOICES           = 16;
   localparam int SAMPLE_ADDR_BITS = 16;
   localparam int SMEM_DEPTH       = 1 << SAMPLE_ADDR_BITS;
   localparam int VOICE_BITS       = 4;
   localparam int DISC_VOICES      = 8;
   localparam int SUM_BITS         = 19;
   localparam int PROD_BITS        = 16;

   localparam logic [VOICE_BITS-1:0] LAST_VOICE_NORM = VOICE_BITS'(VOICES - 1);
   localparam logic [VOICE_BITS-1:0] LAST_VOICE_DISC = VOICE_BITS'(DISC_VOICES - 1);

   localparam logic [7:0] P_BASE_NORM     = 8'h00;
   localparam logic [7:0] P_BASE_DISC     = 8'h40;
   localparam logic [7:0] S_BASE_NORM     = 8'h80;
   localparam logic [7:0] S_BASE_DISC     = 8'hc0;
   localparam logic [7:0] BANK_MASK_FIXED = 8'h70;
   localparam logic [7:0] BANK_MASK_SEL   = 8'hfc;
   localparam logic [7:0] CTL_STOPPED     = 8'h01;
   localparam logic [7:0] REG_RESET_VALUE = 8'hff;
   localparam logic [23:0] BANK_RESET     = 24'h70000c;

   // register offsets inside a voice's parameter (P_) and status (S_) block
   localparam logic [7:0] P_LVOL     = 8'd2;
   localparam logic [7:0] P_RVOL     = 8'd3;
   localparam logic [7:0] P_LOOP_MID = 8'd4;
   localparam logic [7:0] P_LOOP_HI  = 8'd5;
   localparam logic [7:0] P_END      = 8'd6;
   localparam logic [7:0] P_STEP     = 8'd7;
   localparam logic [7:0] S_ADDR_MID = 8'd4;
   localparam logic [7:0] S_ADDR_HI  = 8'd5;
   localparam logic [7:0] S_CTL      = 8'd6;

   localparam logic CSR_DISCRETE = 1'b0;
   localparam logic CSR_BANK     = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      REQ_REG_WR  = 2'd0,
      REQ_REG_RD  = 2'd1,
      REQ_SMEM_WR = 2'd2,
      REQ_TICK    = 2'd3
   } req_kind_type;

   // register memory read pairs
   typedef enum logic [2:0] {
      RD_NONE,
      RD_BUS,
      RD_CTL,
      RD_ADDR,
      RD_LOOP,
      RD_VOL,
      RD_STEP
   } rd_op_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_REG_WR,
      OP_SMEM_WR,
      OP_BUS_RD,
      OP_TICK_START,
      OP_FRAC_CLR,
      OP_STOP_WR,
      OP_ADDR_LOAD,
      OP_SMEM_RD,
      OP_MUL,
      OP_ACC,
      OP_WB_MID,
      OP_WB_HI
   } dp_op_type;

   typedef struct packed {
      logic [VOICE_BITS-1:0] voice;
      rd_op_type             rd_op;
      dp_op_type             op;
   } cmd_type;

   typedef struct packed {
      logic stopped;
      logic one_shot;
      logic at_end;
   } stat_type;

   typedef struct packed {
      logic        discrete_mode;
      logic [23:0] bank_setting;
   } cfg_type;

endpackage

// ===== design/mvpm_csr.sv =====
// Configuration registers: discrete layout select and bank setting.
module mvpm_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [23:0]      csr_wdata,
   output mvpm_pkg::cfg_type cfg
);
   import mvpm_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.discrete_mode <= 1'b0;
         cfg_ff.bank_setting  <= BANK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISCRETE: cfg_ff.discrete_mode <= csr_wdata[0];
            CSR_BANK:     cfg_ff.bank_setting  <= csr_wdata;
            default:      cfg_ff.discrete_mode <= cfg_ff.discrete_mode;
         endcase
      end
   end

endmodule

// ===== design/mvpm_ctrl.sv =====
// Controller: bus request decode and per-voice tick sequencer.
module mvpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_type,
   input  mvpm_pkg::cfg_type  cfg,
   input  mvpm_pkg::stat_type stat,
   output mvpm_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);
   import mvpm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUS_WAIT,
      ST_RD_CTL,
      ST_RD_ADDR,
      ST_RD_LOOP,
      ST_RD_VOL,
      ST_RD_STEP,
      ST_EVAL,
      ST_SMP,
      ST_MUL,
      ST_ACC,
      ST_WB_MID,
      ST_WB_HI,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [VOICE_BITS-1:0] voice_ff, voice_in;
   logic [VOICE_BITS-1:0] last_voice;
   logic                  last;
   state_type             after_voice;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign last_voice = cfg.discrete_mode ? LAST_VOICE_DISC : LAST_VOICE_NORM;
   assign last       = (voice_ff == last_voice);
   assign after_voice = last ? ST_RESP : ST_RD_CTL;

   always_comb begin
      state_in  = state_ff;
      voice_in  = voice_ff;
      cmd.voice = voice_ff;
      cmd.rd_op = RD_NONE;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind_type'(req_type))
                  REQ_REG_WR:  cmd.op = OP_REG_WR;
                  REQ_SMEM_WR: cmd.op = OP_SMEM_WR;
                  REQ_REG_RD: begin
                     cmd.op    = OP_BUS_RD;
                     cmd.rd_op = RD_BUS;
                     state_in  = ST_BUS_WAIT;
                  end
                  REQ_TICK: begin
                     cmd.op   = OP_TICK_START;
                     voice_in = '0;
                     state_in = ST_RD_CTL;
                  end
                  default: cmd.op = OP_NONE;
               endcase
            end
         end
         ST_BUS_WAIT: state_in = ST_RESP;
         ST_RD_CTL: begin
            cmd.rd_op = RD_CTL;
            state_in  = ST_RD_ADDR;
         end
         ST_RD_ADDR: begin
            cmd.rd_op = RD_ADDR;
            state_in  = ST_RD_LOOP;
         end
         ST_RD_LOOP: begin
            cmd.rd_op = RD_LOOP;
            state_in  = ST_RD_VOL;
         end
         ST_RD_VOL: begin
            cmd.rd_op = RD_VOL;
            state_in  = ST_RD_STEP;
         end
         ST_RD_STEP: begin
            cmd.rd_op = RD_STEP;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.stopped) begin
               cmd.op   = OP_FRAC_CLR;
               state_in = after_voice;
               voice_in = voice_ff + 1'b1;
            end else if (stat.at_end && stat.one_shot) begin
               cmd.op   = OP_STOP_WR;
               state_in = after_voice;
               voice_in = voice_ff + 1'b1;
            end else begin
               cmd.op   = OP_ADDR_LOAD;
               state_in = ST_SMP;
            end
         end
         ST_SMP: begin
            cmd.op   = OP_SMEM_RD;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_WB_MID;
         end
         ST_WB_MID: begin
            cmd.op   = OP_WB_MID;
            state_in = ST_WB_HI;
         end
         ST_WB_HI: begin
            cmd.op   = OP_WB_HI;
            state_in = after_voice;
            voice_in = voice_ff + 1'b1;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         voice_ff <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
      end
   end

endmodule

// ===== design/mvpm_dp.sv =====
// Datapath: register memory, sample memory, voice fetch, multiply and mix sums.
module mvpm_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  mvpm_pkg::cmd_type            cmd,
   input  mvpm_pkg::cfg_type            cfg,
   input  logic [15:0]                 req_address,
   input  logic [7:0]                  req_data,
   output mvpm_pkg::stat_type           stat,
   output logic                        rsp_result_kind,
   output logic [7:0]                  rsp_read_data,
   output logic signed [mvpm_pkg::SUM_BITS-1:0] rsp_left_sum,
   output logic signed [mvpm_pkg::SUM_BITS-1:0] rsp_right_sum
);
   import mvpm_pkg::*;

   // register memory: valid bits stand in for the all-ones reset image
   logic [7:0]   regmem_ff [256];
   logic [255:0] valid_ff;
   logic [7:0]   rda_ff, rdb_ff;
   logic         va_ff, vb_ff;
   logic [7:0]   rd_a, rd_b;
   logic [7:0]   rd_a_addr, rd_b_addr;
   logic         wr_en;
   logic [7:0]   wr_addr, wr_data;
   rd_op_type    rd_op_ff;

   logic [7:0]   smem_ff [SMEM_DEPTH];
   logic [7:0]   smp_ff;

   logic [7:0]   frac_ff [1 << VOICE_BITS];

   logic [7:0]   ctl_ff, endpg_ff, amid_ff, ahi_ff, lmid_ff, lhi_ff, step_ff;
   logic [6:0]   lvol_ff, rvol_ff;
   logic [23:0]  addr_ff;
   logic signed [PROD_BITS-1:0] lprod_ff, rprod_ff;
   logic signed [SUM_BITS-1:0]  lsum_ff, rsum_ff;
   logic         kind_ff;
   logic [7:0]   rdata_ff;

   logic [7:0]   p_base, s_base;
   logic [7:0]   bank_mask;
   logic [23:0]  bank, sidx;
   logic signed [7:0]           smp_s8;
   logic signed [PROD_BITS-1:0] smp_s, lvol_s, rvol_s;

   assign p_base = (cfg.discrete_mode ? P_BASE_DISC : P_BASE_NORM)
                 + {1'b0, cmd.voice, 3'b000};
   assign s_base = (cfg.discrete_mode ? S_BASE_DISC : S_BASE_NORM)
                 + {1'b0, cmd.voice, 3'b000};

   assign rd_a = va_ff ? rda_ff : REG_RESET_VALUE;
   assign rd_b = vb_ff ? rdb_ff : REG_RESET_VALUE;

   always_comb begin
      rd_a_addr = req_address[7:0];
      rd_b_addr = req_address[7:0];
      case (cmd.rd_op)
         RD_CTL: begin
            rd_a_addr = s_base + S_CTL;
            rd_b_addr = p_base + P_END;
         end
         RD_ADDR: begin
            rd_a_addr = s_base + S_ADDR_MID;
            rd_b_addr = s_base + S_ADDR_HI;
         end
         RD_LOOP: begin
            rd_a_addr = p_base + P_LOOP_MID;
            rd_b_addr = p_base + P_LOOP_HI;
         end
         RD_VOL: begin
            rd_a_addr = p_base + P_LVOL;
            rd_b_addr = p_base + P_RVOL;
         end
         RD_STEP: begin
            rd_a_addr = p_base + P_STEP;
            rd_b_addr = p_base + P_STEP;
         end
         default: rd_a_addr = req_address[7:0];
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = req_address[7:0];
      wr_data = req_data;
      case (cmd.op)
         OP_REG_WR: wr_en = 1'b1;
         OP_STOP_WR: begin
            wr_addr = s_base + S_CTL;
            wr_data = ctl_ff | CTL_STOPPED;
         end
         OP_WB_MID: begin
            wr_addr = s_base + S_ADDR_MID;
            wr_data = addr_ff[15:8];
         end
         OP_WB_HI: begin
            wr_addr = s_base + S_ADDR_HI;
            wr_data = addr_ff[23:16];
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regmem_ff[wr_addr] <= wr_data;
      end
      rda_ff <= regmem_ff[rd_a_addr];
      rdb_ff <= regmem_ff[rd_b_addr];
      va_ff  <= valid_ff[rd_a_addr];
      vb_ff  <= valid_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_op_ff <= RD_NONE;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_op_ff <= cmd.rd_op;
      end
   end

   // banked sample address, wrapped at the sample memory size
   assign bank_mask = BANK_MASK_FIXED | (cfg.bank_setting[23:16] & BANK_MASK_SEL);
   assign bank = cfg.discrete_mode ? 24'h000000
               : (24'(ctl_ff & bank_mask) << cfg.bank_setting[3:0]);
   assign sidx = bank + {8'h00, addr_ff[23:8]};

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SMEM_WR) begin
         smem_ff[SAMPLE_ADDR_BITS'(req_address)] <= req_data;
      end
      if (cmd.op == OP_SMEM_RD) begin
         smp_ff <= smem_ff[SAMPLE_ADDR_BITS'(sidx)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < (1 << VOICE_BITS); i++) begin
            frac_ff[i] <= '0;
         end
      end else if (cmd.op == OP_FRAC_CLR) begin
         frac_ff[cmd.voice] <= '0;
      end else if (cmd.op == OP_WB_HI) begin
         frac_ff[cmd.voice] <= addr_ff[7:0];
      end
   end

   // offset binary to two's complement: flip the top bit
   assign smp_s8 = signed'({~smp_ff[7], smp_ff[6:0]});
   assign smp_s  = PROD_BITS'(smp_s8);
   assign lvol_s = signed'({{(PROD_BITS-7){1'b0}}, lvol_ff});
   assign rvol_s = signed'({{(PROD_BITS-7){1'b0}}, rvol_ff});

   always_ff @(posedge clock) begin
      case (rd_op_ff)
         RD_BUS:  rdata_ff <= rd_a;
         RD_CTL: begin
            ctl_ff   <= rd_a;
            endpg_ff <= rd_b;
         end
         RD_ADDR: begin
            amid_ff <= rd_a;
            ahi_ff  <= rd_b;
         end
         RD_LOOP: begin
            lmid_ff <= rd_a;
            lhi_ff  <= rd_b;
         end
         RD_VOL: begin
            lvol_ff <= rd_a[6:0];
            rvol_ff <= rd_b[6:0];
         end
         RD_STEP: step_ff <= rd_a;
         default: step_ff <= step_ff;
      endcase
      case (cmd.op)
         OP_BUS_RD: begin
            kind_ff <= KIND_READ;
            lsum_ff <= '0;
            rsum_ff <= '0;
         end
         OP_TICK_START: begin
            kind_ff  <= KIND_TICK;
            rdata_ff <= '0;
            lsum_ff  <= '0;
            rsum_ff  <= '0;
         end
         OP_ADDR_LOAD: begin
            if (stat.at_end) begin
               addr_ff <= {lhi_ff, lmid_ff, 8'h00};
            end else begin
               addr_ff <= {ahi_ff, amid_ff, frac_ff[cmd.voice]};
            end
         end
         OP_MUL: begin
            lprod_ff <= smp_s * lvol_s;
            rprod_ff <= smp_s * rvol_s;
         end
         OP_ACC: begin
            lsum_ff <= lsum_ff + SUM_BITS'(lprod_ff);
            rsum_ff <= rsum_ff + SUM_BITS'(rprod_ff);
            addr_ff <= addr_ff + {16'h0000, step_ff};
         end
         default: kind_ff <= kind_ff;
      endcase
   end

   assign stat.stopped  = ctl_ff[0];
   assign stat.one_shot = ctl_ff[1];
   assign stat.at_end   = (ahi_ff == 8'(endpg_ff + 8'd1));

   assign rsp_result_kind = kind_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_left_sum    = lsum_ff;
   assign rsp_right_sum   = rsum_ff;

endmodule

// ===== design/multi_voice_pcm_sample_mixer_top.sv =====
// Top level of the multi-voice PCM sample mixer: controller, datapath, CSRs.
//
//   channel   handshake                  payload
//   req       start / busy               req_type, req_address, req_data
//   rsp       rsp_strobe (one cycle)     rsp_result_kind, rsp_read_data,
//                                        rsp_left_sum, rsp_right_sum
//   csr       csr_valid / csr_ready      csr_index, csr_wdata
//
// A register read passes the memory output and read data registers, then its
// word comes with rsp_strobe. A tick reads five register pairs per voice; a
// playing voice then reads its sample, multiplies, accumulates and writes back
// its address, as set by the two read ports and single write port of the
// register memory. Synchronous reset clears control state and the register
// memory valid bits, so every register byte reads as all ones at once; there is
// no clearing pass. The receiver cannot stall; csr_ready is always high.
module multi_voice_pcm_sample_mixer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [15:0]                       req_address,
   input  logic [7:0]                        req_data,
   output logic                              rsp_strobe,
   output logic                              rsp_result_kind,
   output logic [7:0]                        rsp_read_data,
   output logic signed [mvpm_pkg::SUM_BITS-1:0] rsp_left_sum,
   output logic signed [mvpm_pkg::SUM_BITS-1:0] rsp_right_sum,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [23:0]                       csr_wdata
);
   import mvpm_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   mvpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mvpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .cfg        (cfg),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mvpm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_address     (req_address),
      .req_data        (req_data),
      .stat            (stat),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_left_sum    (rsp_left_sum),
      .rsp_right_sum   (rsp_right_sum)
   );

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_work_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_TICK || req_type == REQ_REG_RD)) |=> busy)
      else $error("read or tick accepted without starting work");

   a_read_zero_sums: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == KIND_READ) |->
         (rsp_left_sum == '0 && rsp_right_sum == '0))
      else $error("register read word carries non-zero sums");

endmodule
